>>> rtl/dq_pkg.sv
`timescale 1ns / 1ps

package dq_pkg;

  // Ring geometry. Slot indices wrap by truncation, so CAPACITY is a power of two.
  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int WORD_W   = 32;

  // Command codes; the unused codes act as a peek
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_PEEK       = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]               command;
    logic signed [WORD_W-1:0] push_value;
  } cmd_word_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] popped_value;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] back_value;
    logic [CNT_W-1:0]         element_count;
    logic                     is_empty;
    logic [1:0]               status;
  } res_word_t;

endpackage

>>> rtl/dq_ram.sv
`timescale 1ns / 1ps

module dq_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one slot per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/double_ended_queue_top.sv
`timescale 1ns / 1ps
// Channel  | Handshake            | Payload               | Words
// cmd      | cmd_valid/cmd_ready  | cmd_word (cmd_word_t) | one command in
// res      | res_valid/res_ready  | res_word (res_word_t) | one result out per command
//
// Push and peek go from S_IDLE straight to S_DONE; a pop that leaves
// elements passes through S_FILL first: the new end value is read back from
// the slot RAM, which has a registered read. One command is in flight at a time.
// Front and back values are cached in registers; the RAM holds the ring.
// rst is synchronous; it empties the deque. The RAM needs no clearing pass.
// A stalled result sits in the output register while the next command is taken.

module double_ended_queue_top
  import dq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  cmd_word_t cmd_word,
  output logic      res_valid,
  input  logic      res_ready,
  output res_word_t res_word
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FILL,
    S_DONE
  } state_t;

  state_t                   state;
  logic [IDX_W-1:0]         front_idx;
  logic [CNT_W-1:0]         count;
  logic signed [WORD_W-1:0] front_val;
  logic signed [WORD_W-1:0] back_val;
  logic signed [WORD_W-1:0] popped;
  logic [1:0]               status;
  logic                     fill_front;

  logic                     accept;
  logic                     empty;
  logic                     full;
  logic                     wr_en;
  logic [IDX_W-1:0]         wr_addr;
  logic [IDX_W-1:0]         rd_addr;
  logic [WORD_W-1:0]        rd_data;
  logic [IDX_W-1:0]         cnt_lo;

  assign cmd_ready = (state == S_IDLE);
  assign accept    = cmd_valid && cmd_ready;
  assign empty     = (count == '0);
  assign full      = (count == CNT_W'(CAPACITY));
  assign cnt_lo    = count[IDX_W-1:0];

  // Decode the slot write for a push and the slot read for a pop
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = front_idx + cnt_lo;
    rd_addr = front_idx + IDX_W'(1);
    if (accept) begin
      unique case (cmd_word.command)
        CMD_PUSH_FRONT: begin
          wr_en   = !full;
          wr_addr = front_idx - IDX_W'(1);
        end
        CMD_PUSH_BACK: begin
          wr_en   = !full;
        end
        CMD_POP_BACK: begin
          rd_addr = front_idx + cnt_lo - IDX_W'(2);
        end
        default: begin
        end
      endcase
    end
  end

  dq_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (WORD_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (cmd_word.push_value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequence one command: update indices, refill a cached end, post the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front_idx <= '0;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready && state != S_DONE) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            popped <= '0;
            status <= ST_OK;
            state  <= S_DONE;
            unique case (cmd_word.command)
              CMD_PUSH_FRONT: begin
                if (full) begin
                  status <= ST_FULL;
                end else begin
                  front_idx <= front_idx - IDX_W'(1);
                  front_val <= cmd_word.push_value;
                  if (empty) begin
                    back_val <= cmd_word.push_value;
                  end
                  count <= count + CNT_W'(1);
                end
              end
              CMD_PUSH_BACK: begin
                if (full) begin
                  status <= ST_FULL;
                end else begin
                  back_val <= cmd_word.push_value;
                  if (empty) begin
                    front_val <= cmd_word.push_value;
                  end
                  count <= count + CNT_W'(1);
                end
              end
              CMD_POP_FRONT, CMD_POP_BACK: begin
                if (empty) begin
                  status <= ST_EMPTY;
                end else begin
                  popped     <= (cmd_word.command == CMD_POP_FRONT) ? front_val : back_val;
                  count      <= count - CNT_W'(1);
                  fill_front <= (cmd_word.command == CMD_POP_FRONT);
                  if (count == CNT_W'(1)) begin
                    front_idx <= '0;
                  end else begin
                    if (cmd_word.command == CMD_POP_FRONT) begin
                      front_idx <= front_idx + IDX_W'(1);
                    end
                    state <= S_FILL;
                  end
                end
              end
              default: begin
                if (empty) begin
                  status <= ST_EMPTY;
                end
              end
            endcase
          end
        end
        S_FILL: begin
          if (fill_front) begin
            front_val <= rd_data;
          end else begin
            back_val <= rd_data;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!res_valid || res_ready) begin
            res_valid              <= 1'b1;
            res_word.popped_value  <= popped;
            res_word.front_value   <= empty ? '0 : front_val;
            res_word.back_value    <= empty ? '0 : back_val;
            res_word.element_count <= count;
            res_word.is_empty      <= empty;
            res_word.status        <= status;
            state                  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/dq_checker.sv
`timescale 1ns / 1ps

module dq_checker
  import dq_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      res_valid,
  input logic      res_ready,
  input res_word_t res_word
);

  // Hold a stalled result word
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_word))
    else $error("result word changed while stalled");

  // Flag empty exactly when the count is zero
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_word.is_empty == (res_word.element_count == '0))
    else $error("empty flag disagrees with count");

  // Drive zero end values on an empty deque
  a_empty_vals: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_word.is_empty |-> res_word.front_value == '0 &&
                                       res_word.back_value == '0)
    else $error("nonzero end value on empty deque");

  // Reject a push only when the deque is full
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_word.status == ST_FULL |->
      res_word.element_count == CNT_W'(CAPACITY))
    else $error("full status without a full deque");

  // Drop any result after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind double_ended_queue_top dq_checker u_dq_checker (.*);
